@@ rtl/integer_to_ascii_formatter_macros.svh @@
// Assertion macros shared by the formatter RTL.
`ifndef INTEGER_TO_ASCII_FORMATTER_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_MACROS_SVH

`ifndef SYNTHESIS
`define ITA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");
`define ITA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");
`else
`define ITA_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ITA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/ita_pkg.sv @@
// Shared types, constants and character table for the integer-to-ASCII formatter.
package ita_pkg;

    localparam int VAL_W      = 32;
    localparam int CHAR_W     = 8;
    localparam int DIGIT_W    = 4;
    localparam int MAX_DIGITS = 10;
    localparam int IDX_W      = $clog2(MAX_DIGITS);
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);

    // ceil(2^35 / 10): q = (v * DIV10_MUL) >> 35 is exact for all 32-bit v
    localparam logic [VAL_W-1:0] DIV10_MUL   = 32'hCCCC_CCCD;
    localparam int               DIV10_SHIFT = 35;
    localparam logic [3:0]       HEX_SHIFT   = 4'd4;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_X     = 8'h78;

    localparam logic [CHAR_W-1:0] HEX_DIGITS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };

    typedef enum logic [1:0] {
        KIND_SDEC    = 2'd0,
        KIND_UDEC    = 2'd1,
        KIND_HEX     = 2'd2,
        KIND_HEX_PFX = 2'd3
    } t_kind;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [IDX_W-1:0] raddr;
    } t_stk_ctl;

endpackage

@@ rtl/integer_to_ascii_formatter.sv @@
// Top level: sequencer, digit unit and stack, and output register of the formatter.
// Each request (value, kind) is converted one digit per cycle by a single shared
// divide-by-10 (reciprocal multiply) / shift-by-4 unit, for D = 1 to 10 digits,
// then its text leaves one character per cycle, while the output does not stall,
// through the output register: sign or 0x prefix first, then digits most
// significant first, tlast on the final one. A request yields N = 1 to 11
// characters; s_tready stays low after the accept until its final character has
// entered the output register.
// The next request is taken while the final character still waits in the output
// register.
`include "integer_to_ascii_formatter_macros.svh"

module integer_to_ascii_formatter (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [ita_pkg::VAL_W-1:0]    i_s_tdata,   // [31:0] value
    input  logic [1:0]                   i_s_tuser,   // [1:0] req_type
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [ita_pkg::CHAR_W-1:0]   o_m_tdata,   // [7:0] char_code
    output logic                         o_m_tlast
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CONV = 4'b0010,
        S_PRE  = 4'b0100,
        S_DIG  = 4'b1000
    } t_state;

    t_state                          r_state, n_state;
    ita_pkg::t_kind                  r_kind, n_kind;
    logic                            r_neg, n_neg;
    logic                            r_pfx_step, n_pfx_step;
    logic [ita_pkg::VAL_W-1:0]       r_val, n_val;
    logic [ita_pkg::CNT_W-1:0]       r_nd, n_nd;
    logic                            r_ovalid, n_ovalid;
    logic [ita_pkg::CHAR_W-1:0]      r_odata, n_odata;
    logic                            r_olast, n_olast;

    logic                            w_accept;
    logic                            w_slot;
    logic                            w_in_neg;
    ita_pkg::t_kind                  w_in_kind;
    logic [ita_pkg::VAL_W-1:0]       w_quot;
    logic [ita_pkg::DIGIT_W-1:0]     w_digit;
    logic [ita_pkg::DIGIT_W-1:0]     w_rdigit;
    ita_pkg::t_stk_ctl               w_stk;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_slot     = !r_ovalid || i_m_tready;
    assign w_in_kind  = ita_pkg::t_kind'(i_s_tuser);
    assign w_in_neg   = (w_in_kind == ita_pkg::KIND_SDEC) && i_s_tdata[ita_pkg::VAL_W-1];

    ita_digit_unit u_digit_unit (
        .i_hex   (r_kind == ita_pkg::KIND_HEX || r_kind == ita_pkg::KIND_HEX_PFX),
        .i_val   (r_val),
        .o_quot  (w_quot),
        .o_digit (w_digit)
    );

    // read address follows the next digit count so the registered read lines up
    assign w_stk.we    = (r_state == S_CONV);
    assign w_stk.waddr = r_nd[ita_pkg::IDX_W-1:0];
    assign w_stk.raddr = ita_pkg::IDX_W'(n_nd - ita_pkg::CNT_W'(1));

    ita_digit_stack u_digit_stack (
        .i_clk   (i_clk),
        .i_ctl   (w_stk),
        .i_digit (w_digit),
        .o_digit (w_rdigit)
    );

    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        n_neg      = r_neg;
        n_pfx_step = r_pfx_step;
        n_val      = r_val;
        n_nd       = r_nd;
        n_ovalid   = r_ovalid && !i_m_tready;
        n_odata    = r_odata;
        n_olast    = r_olast;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_kind     = w_in_kind;
                    n_neg      = w_in_neg;
                    n_pfx_step = 1'b0;
                    n_val      = w_in_neg ? (ita_pkg::VAL_W'(0) - i_s_tdata) : i_s_tdata;
                    n_nd       = '0;
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                n_val = w_quot;
                n_nd  = r_nd + ita_pkg::CNT_W'(1);
                if (w_quot == '0) begin
                    n_state = (r_neg || r_kind == ita_pkg::KIND_HEX_PFX) ? S_PRE : S_DIG;
                end
            end
            S_PRE: begin
                if (w_slot) begin
                    n_ovalid = 1'b1;
                    n_olast  = 1'b0;
                    if (r_neg) begin
                        n_odata = ita_pkg::CHAR_MINUS;
                        n_state = S_DIG;
                    end else if (r_pfx_step) begin
                        n_odata = ita_pkg::CHAR_X;
                        n_state = S_DIG;
                    end else begin
                        n_odata    = ita_pkg::CHAR_ZERO;
                        n_pfx_step = 1'b1;
                    end
                end
            end
            S_DIG: begin
                if (w_slot) begin
                    n_ovalid = 1'b1;
                    n_odata  = ita_pkg::HEX_DIGITS[w_rdigit];
                    n_olast  = (r_nd == ita_pkg::CNT_W'(1));
                    n_nd     = r_nd - ita_pkg::CNT_W'(1);
                    if (r_nd == ita_pkg::CNT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_nd     <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_nd     <= n_nd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_neg      <= n_neg;
        r_pfx_step <= n_pfx_step;
        r_val      <= n_val;
        r_odata    <= n_odata;
        r_olast    <= n_olast;
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tlast  = r_olast;

    `ITA_ASSERT_SAME(a_nd_bound, i_clk, i_rst_n, 1'b1,
        r_nd <= ita_pkg::CNT_W'(ita_pkg::MAX_DIGITS))
    `ITA_ASSERT_NEXT(a_accept_conv, i_clk, i_rst_n, w_accept,
        r_state == S_CONV && r_nd == '0)
    `ITA_ASSERT_NEXT(a_last_done, i_clk, i_rst_n,
        r_state == S_DIG && w_slot && r_nd == ita_pkg::CNT_W'(1),
        r_state == S_IDLE && o_m_tvalid && o_m_tlast)
    `ITA_ASSERT_SAME(a_pre_reason, i_clk, i_rst_n, r_state == S_PRE,
        r_neg || r_kind == ita_pkg::KIND_HEX_PFX)

endmodule

@@ rtl/ita_digit_unit.sv @@
// Shared digit extractor: splits a value into quotient and low digit, base 10 or 16.
module ita_digit_unit (
    input  logic                          i_hex,
    input  logic [ita_pkg::VAL_W-1:0]     i_val,
    output logic [ita_pkg::VAL_W-1:0]     o_quot,
    output logic [ita_pkg::DIGIT_W-1:0]   o_digit
);

    logic [2*ita_pkg::VAL_W-1:0] w_prod;
    logic [ita_pkg::VAL_W-1:0]   w_q10;
    logic [ita_pkg::VAL_W-1:0]   w_q10x;
    logic [ita_pkg::VAL_W-1:0]   w_r10;

    assign w_prod = (2*ita_pkg::VAL_W)'(i_val) * (2*ita_pkg::VAL_W)'(ita_pkg::DIV10_MUL);
    assign w_q10  = ita_pkg::VAL_W'(w_prod >> ita_pkg::DIV10_SHIFT);
    assign w_q10x = (w_q10 << 3) + (w_q10 << 1);
    assign w_r10  = i_val - w_q10x;

    always_comb begin
        if (i_hex) begin
            o_quot  = i_val >> ita_pkg::HEX_SHIFT;
            o_digit = i_val[ita_pkg::DIGIT_W-1:0];
        end else begin
            o_quot  = w_q10;
            o_digit = w_r10[ita_pkg::DIGIT_W-1:0];
        end
    end

endmodule

@@ rtl/ita_digit_stack.sv @@
// Digit stack: holds digits least significant first, read back in reverse.
module ita_digit_stack (
    input  logic                          i_clk,
    input  ita_pkg::t_stk_ctl             i_ctl,
    input  logic [ita_pkg::DIGIT_W-1:0]   i_digit,
    output logic [ita_pkg::DIGIT_W-1:0]   o_digit
);

    logic [ita_pkg::DIGIT_W-1:0] r_mem [ita_pkg::MAX_DIGITS];
    logic [ita_pkg::DIGIT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_ctl.waddr] <= i_digit;
        end
    end

    // registered read; a digit written this cycle to the read address is forwarded
    always_ff @(posedge i_clk) begin
        if (i_ctl.we && i_ctl.waddr == i_ctl.raddr) begin
            r_rdata <= i_digit;
        end else begin
            r_rdata <= r_mem[i_ctl.raddr];
        end
    end

    assign o_digit = r_rdata;

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for integer_to_ascii_formatter: random stream traffic with text prediction.
`timescale 1ns / 100ps

module tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;
    localparam int RANDOM_REQS    = 156;

    localparam logic [7:0] ASCII_0     = 8'h30;
    localparam logic [7:0] ASCII_A     = 8'h61;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;
    localparam logic [7:0] ASCII_X     = 8'h78;

    localparam logic [31:0] CORNER_VALS [6] = '{
        32'h0000_0000, 32'h0000_0001, 32'h0000_000A,
        32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF
    };

    typedef struct {
        logic           drain;
        ita_pkg::t_kind kind;
        logic [31:0]    value;
    } t_req;

    typedef struct {
        logic [7:0] code;
        logic       last;
    } t_char;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [31:0] i_s_tdata;   // [31:0] value
    logic [1:0]  i_s_tuser;   // [1:0] req_type
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [7:0]  o_m_tdata;   // [7:0] char_code
    logic        o_m_tlast;

    t_req  pending_reqs [$];
    t_char expected_chars [$];
    t_req  next_req;
    t_char got_char;
    logic  s_taken;
    int    taken_cnt;
    int    idle_cycles;
    int    text_errors;
    wire   calm = (taken_cnt >= 100 && taken_cnt < 150);

    integer_to_ascii_formatter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic void predict_text(input ita_pkg::t_kind kind, input logic [31:0] value);
        logic [31:0] mag;
        logic [7:0]  text [$];
        logic [7:0]  digits [$];
        logic [7:0]  nib;
        t_char       c;
        mag = value;
        if (kind == ita_pkg::KIND_SDEC && value[31]) begin
            text.push_back(ASCII_MINUS);
            mag = 32'd0 - value;
        end
        if (kind == ita_pkg::KIND_HEX_PFX) begin
            text.push_back(ASCII_0);
            text.push_back(ASCII_X);
        end
        if (mag == 32'd0)
            digits.push_front(ASCII_0);
        while (mag != 32'd0) begin
            if (kind == ita_pkg::KIND_HEX || kind == ita_pkg::KIND_HEX_PFX) begin
                nib = {4'd0, mag[3:0]};
                digits.push_front(nib < 8'd10 ? ASCII_0 + nib : ASCII_A + nib - 8'd10);
                mag = mag >> 4;
            end else begin
                digits.push_front(ASCII_0 + 8'(mag % 32'd10));
                mag = mag / 32'd10;
            end
        end
        foreach (digits[i]) text.push_back(digits[i]);
        foreach (text[i]) begin
            c.code = text[i];
            c.last = (i == text.size() - 1);
            expected_chars.push_back(c);
        end
    endfunction

    task automatic add_req(input logic drain, input ita_pkg::t_kind kind,
                           input logic [31:0] value);
        t_req r;
        r.drain = drain;
        r.kind  = kind;
        r.value = value;
        pending_reqs.push_back(r);
    endtask

    task automatic note_error(input string msg);
        if (text_errors < REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
        text_errors++;
    endtask

    // request driver
    always @(negedge i_clk) begin
        if (i_rst_n && !(i_s_tvalid && !s_taken)) begin
            if (pending_reqs.size() > 0 && pending_reqs[0].drain) begin
                if (expected_chars.size() == 0) void'(pending_reqs.pop_front());
                i_s_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 10)) begin
                next_req = pending_reqs.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= next_req.value;
                i_s_tuser  <= next_req.kind;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            i_m_tready <= calm || $urandom_range(99) >= 10;
        end
    end

    // monitor and checker
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            s_taken <= i_s_tvalid && o_s_tready;
            if (i_s_tvalid && o_s_tready) begin
                predict_text(ita_pkg::t_kind'(i_s_tuser), i_s_tdata);
                taken_cnt <= taken_cnt + 1;
            end
            if (o_m_tvalid && i_m_tready) begin
                if (expected_chars.size() == 0) begin
                    note_error($sformatf("unexpected char %h last %b", o_m_tdata, o_m_tlast));
                end else begin
                    got_char = expected_chars.pop_front();
                    if (o_m_tdata !== got_char.code || o_m_tlast !== got_char.last)
                        note_error($sformatf("char exp %h last %b, got %h last %b",
                            got_char.code, got_char.last, o_m_tdata, o_m_tlast));
                end
            end
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("FAIL");
                    $finish;
                end
            end
        end
    end

    initial begin
        logic [31:0] v;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = '0;
        i_m_tready  = 1'b0;
        s_taken     = 1'b0;
        taken_cnt   = 0;
        idle_cycles = 0;
        text_errors = 0;

        for (int k = 0; k < 4; k++)
            foreach (CORNER_VALS[j]) add_req(1'b0, ita_pkg::t_kind'(k), CORNER_VALS[j]);
        add_req(1'b1, ita_pkg::KIND_SDEC, '0);
        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (n == RANDOM_REQS / 2) add_req(1'b1, ita_pkg::KIND_SDEC, '0);
            case ($urandom_range(3))
                0: v = $urandom;
                1: v = $urandom_range(20);
                2: v = $urandom >> $urandom_range(31);
                default: v = 32'd0 - $urandom_range(1, 20);
            endcase
            add_req(1'b0, ita_pkg::t_kind'($urandom_range(3)), v);
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        while (pending_reqs.size() > 0 || i_s_tvalid) @(posedge i_clk);
        while (expected_chars.size() > 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);

        if (text_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/ita_pkg.sv
rtl/ita_digit_unit.sv
rtl/ita_digit_stack.sv
rtl/integer_to_ascii_formatter.sv
verif/tb.sv
